// ----- sv/ddmf_pkg.sv -----
// ----------------------------------------------------------------------------
// ddmf_pkg
// Shared types, constants and helpers for the differential drive mixer.
// ----------------------------------------------------------------------------
package ddmf_pkg;

    localparam int TIME_BITS   = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_CNT_W   = $clog2(TIME_BITS + 1);

    localparam int Q_ONE      = 32768;
    localparam int ACTIVE_MIN = 33;
    localparam int DUTY_SCALE = 255;
    localparam int DUTY_MAX   = 255;

    localparam logic signed [15:0] Q_MIN = 16'sh8000;
    localparam logic signed [15:0] Q_MAX = 16'sh7FFF;

    localparam logic [1:0] OP_DRIVE = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_STEER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SPEED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF   = 3'd6;

    localparam logic [14:0] RST_DEADZONE   = 15'd1638;
    localparam logic [14:0] RST_SPIN_SPEED = 15'd22938;
    localparam logic [15:0] RST_TIMEOUT    = 16'd600;
    localparam logic [15:0] RST_BLINK_HALF = 16'd500;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam logic [1:0] PINS_OFF = 2'b00;
    localparam logic [1:0] PINS_FWD = 2'b01;
    localparam logic [1:0] PINS_REV = 2'b10;

    typedef struct packed {
        logic        invert_left;
        logic        invert_right;
        logic        invert_steer;
        logic [14:0] deadzone;
        logic [14:0] spin_speed;
        logic [15:0] timeout_ticks;
        logic [15:0] blink_half_period;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] base;
        logic [15:0]        factor;
        logic [1:0]         side;
    } cmd_t;

    typedef struct packed {
        logic [1:0] left_pins;
        logic [7:0] left_duty;
        logic [1:0] right_pins;
        logic [7:0] right_duty;
        logic       led_on;
        logic       failsafe;
    } res_t;

    typedef struct packed {
        logic                 start;
        logic [TIME_BITS-1:0] dividend;
        logic [15:0]          divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic q_lsb;
    } div_rsp_t;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [15:0] m;
        m = v[15] ? 16'(-v) : 16'(v);
        return m;
    endfunction

endpackage

// ----- sv/ddmf_queue.sv -----
// ----------------------------------------------------------------------------
// ddmf_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module ddmf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ddmf_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output ddmf_pkg::cmd_t pop_data,
    output logic          empty
);
    import ddmf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(QUEUE_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- sv/ddmf_front.sv -----
// ----------------------------------------------------------------------------
// ddmf_front
// Config registers, input acceptance and steer/throttle classification.
// ----------------------------------------------------------------------------
module ddmf_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic signed [15:0]                 steer_value,
    input  logic signed [15:0]                 throttle_value,
    input  logic                               cfg_we,
    input  logic [ddmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ddmf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               q_full,
    output logic                               q_push,
    output ddmf_pkg::cmd_t                     q_data,
    output ddmf_pkg::cfg_t                     cfg
);
    import ddmf_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic signed [15:0] s_inv;
    logic [15:0]        s_mag, t_mag;
    logic signed [15:0] s_dz, t_dz;
    logic [15:0]        s_dz_mag, t_dz_mag;
    logic               s_act, t_act;

    assign cfg      = cfg_reg;
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INVERT_LEFT:  cfg_next.invert_left       = cfg_data[0];
                CFG_INVERT_RIGHT: cfg_next.invert_right      = cfg_data[0];
                CFG_INVERT_STEER: cfg_next.invert_steer      = cfg_data[0];
                CFG_DEADZONE:     cfg_next.deadzone          = cfg_data[14:0];
                CFG_SPIN_SPEED:   cfg_next.spin_speed        = cfg_data[14:0];
                CFG_TIMEOUT:      cfg_next.timeout_ticks     = cfg_data[15:0];
                CFG_BLINK_HALF:   cfg_next.blink_half_period = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_left       <= 1'b0;
            cfg_reg.invert_right      <= 1'b0;
            cfg_reg.invert_steer      <= 1'b1;
            cfg_reg.deadzone          <= RST_DEADZONE;
            cfg_reg.spin_speed        <= RST_SPIN_SPEED;
            cfg_reg.timeout_ticks     <= RST_TIMEOUT;
            cfg_reg.blink_half_period <= RST_BLINK_HALF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // steer negation saturates, then deadzone on both values
    always_comb
    begin
        if (cfg_reg.invert_steer)
        begin
            s_inv = (steer_value == Q_MIN) ? Q_MAX : -steer_value;
        end
        else
        begin
            s_inv = steer_value;
        end
        s_mag    = mag16(s_inv);
        t_mag    = mag16(throttle_value);
        s_dz     = (s_mag < {1'b0, cfg_reg.deadzone}) ? 16'sd0 : s_inv;
        t_dz     = (t_mag < {1'b0, cfg_reg.deadzone}) ? 16'sd0 : throttle_value;
        s_dz_mag = mag16(s_dz);
        t_dz_mag = mag16(t_dz);
        s_act    = (s_dz_mag >= 16'(ACTIVE_MIN));
        t_act    = (t_dz_mag >= 16'(ACTIVE_MIN));

        q_data.op = operation;
        priority if (t_act)
        begin
            q_data.base = t_dz;
        end
        else if (s_act)
        begin
            q_data.base = signed'({1'b0, cfg_reg.spin_speed});
        end
        else
        begin
            q_data.base = 16'sd0;
        end
        q_data.factor = 16'(17'(Q_ONE) - 17'(s_dz_mag));
        priority if (s_dz == 16'sd0)
        begin
            q_data.side = SIDE_NONE;
        end
        else if (s_dz[15])
        begin
            q_data.side = SIDE_LEFT;
        end
        else
        begin
            q_data.side = SIDE_RIGHT;
        end
    end

endmodule

// ----- sv/ddmf_div.sv -----
// ----------------------------------------------------------------------------
// ddmf_div
// Bit-serial restoring divider giving the low quotient bit for the LED blink.
// ----------------------------------------------------------------------------
module ddmf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ddmf_pkg::div_req_t req,
    output ddmf_pkg::div_rsp_t rsp
);
    import ddmf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 q_lsb_reg, q_lsb_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] dvd_reg, dvd_next;
    logic [15:0]          dvs_reg, dvs_next;
    logic [15:0]          rem_reg, rem_next;
    logic [16:0]          trial;
    logic                 q_bit;

    assign rsp.done  = done_reg;
    assign rsp.q_lsb = q_lsb_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        q_lsb_next = q_lsb_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg, dvd_reg[TIME_BITS-1]};
        q_bit      = (trial >= {1'b0, dvs_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(TIME_BITS);
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = q_bit ? 16'(trial - {1'b0, dvs_reg}) : trial[15:0];
            dvd_next = {dvd_reg[TIME_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                q_lsb_next = q_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_lsb_reg <= q_lsb_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        rem_reg   <= rem_next;
    end

endmodule

// ----- sv/ddmf_back.sv -----
// ----------------------------------------------------------------------------
// ddmf_back
// Mixer multiply, duty mapping, watchdog and result register.
// ----------------------------------------------------------------------------
module ddmf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ddmf_pkg::cfg_t cfg,
    input  logic           q_empty,
    input  ddmf_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output ddmf_pkg::res_t res
);
    import ddmf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DUTY = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]           state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic signed [15:0]   l_reg, l_next, r_reg, r_next;
    logic [TIME_BITS-1:0] time_reg, time_next, last_reg, last_next;
    logic [1:0]           lpins_reg, lpins_next, rpins_reg, rpins_next;
    logic [7:0]           lduty_reg, lduty_next, rduty_reg, rduty_next;
    logic                 fs_reg, fs_next, led_reg, led_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 res_reg, res_next;

    logic [15:0]          base_mag;
    logic [31:0]          prod;
    logic signed [15:0]   v_mul;
    logic [15:0]          lmag, rmag;
    logic [23:0]          lprod, rprod;
    logic [7:0]           lduty_calc, rduty_calc;
    logic [1:0]           lpins_calc, rpins_calc;
    logic [TIME_BITS-1:0] elapsed;
    logic                 fs_calc;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    ddmf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // mix product, truncated toward zero
    always_comb
    begin
        base_mag = mag16(cmd_reg.base);
        prod     = base_mag * cmd_reg.factor;
        v_mul    = cmd_reg.base[15] ? -signed'(prod[30:15]) : signed'(prod[30:15]);
    end

    // duty and pin pair per wheel, and the watchdog timeout check
    always_comb
    begin
        lmag       = mag16(l_reg);
        rmag       = mag16(r_reg);
        lprod      = lmag * 8'(DUTY_SCALE);
        rprod      = rmag * 8'(DUTY_SCALE);
        lduty_calc = (lprod[23:15] > 9'(DUTY_MAX)) ? 8'(DUTY_MAX) : lprod[22:15];
        rduty_calc = (rprod[23:15] > 9'(DUTY_MAX)) ? 8'(DUTY_MAX) : rprod[22:15];
        if (lduty_calc == 8'd0)
        begin
            lpins_calc = PINS_OFF;
        end
        else
        begin
            lpins_calc = (!l_reg[15] != cfg.invert_left) ? PINS_FWD : PINS_REV;
        end
        if (rduty_calc == 8'd0)
        begin
            rpins_calc = PINS_OFF;
        end
        else
        begin
            rpins_calc = (!r_reg[15] != cfg.invert_right) ? PINS_FWD : PINS_REV;
        end
        elapsed = time_reg - last_reg;
        fs_calc = (elapsed > TIME_BITS'(cfg.timeout_ticks));
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        time_next      = time_reg;
        last_next      = last_reg;
        lpins_next     = lpins_reg;
        lduty_next     = lduty_reg;
        rpins_next     = rpins_reg;
        rduty_next     = rduty_reg;
        fs_next        = fs_reg;
        led_next       = led_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;

        div_req.start    = 1'b0;
        div_req.dividend = time_reg;
        div_req.divisor  = (cfg.blink_half_period == 16'd0) ? 16'd1 : cfg.blink_half_period;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next   = q_data;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                l_next = (cmd_reg.side == SIDE_LEFT) ? v_mul : cmd_reg.base;
                r_next = (cmd_reg.side == SIDE_RIGHT) ? v_mul : cmd_reg.base;
                if (cmd_reg.op == OP_TICK)
                begin
                    time_next = time_reg + 1'b1;
                end
                else if (cmd_reg.op == OP_DRIVE || cmd_reg.op == OP_STOP)
                begin
                    last_next = time_reg;
                end
                state_next = ST_DUTY;
            end
            ST_DUTY:
            begin
                if (cmd_reg.op == OP_DRIVE)
                begin
                    lpins_next = lpins_calc;
                    lduty_next = lduty_calc;
                    rpins_next = rpins_calc;
                    rduty_next = rduty_calc;
                end
                if (cmd_reg.op == OP_STOP || fs_calc)
                begin
                    lpins_next = PINS_OFF;
                    lduty_next = 8'd0;
                    rpins_next = PINS_OFF;
                    rduty_next = 8'd0;
                end
                fs_next  = fs_calc;
                led_next = 1'b1;
                if (fs_calc)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    led_next   = !div_rsp.q_lsb;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    res_next.left_pins  = lpins_reg;
                    res_next.left_duty  = lduty_reg;
                    res_next.right_pins = rpins_reg;
                    res_next.right_duty = rduty_reg;
                    res_next.led_on     = led_reg;
                    res_next.failsafe   = fs_reg;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
            last_reg      <= '0;
            lpins_reg     <= PINS_OFF;
            lduty_reg     <= 8'd0;
            rpins_reg     <= PINS_OFF;
            rduty_reg     <= 8'd0;
            fs_reg        <= 1'b0;
            led_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            last_reg      <= last_next;
            lpins_reg     <= lpins_next;
            lduty_reg     <= lduty_next;
            rpins_reg     <= rpins_next;
            rduty_reg     <= rduty_next;
            fs_reg        <= fs_next;
            led_reg       <= led_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        res_reg <= res_next;
    end

    a_div_only_failsafe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> fs_reg)
        else $error("divider running outside failsafe");

    a_failsafe_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.failsafe) |->
            (res_reg.left_duty == 8'd0 && res_reg.right_duty == 8'd0))
        else $error("motors driven in failsafe");

    a_left_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (lpins_reg != 2'b11) && ((lpins_reg != PINS_OFF) == (lduty_reg != 8'd0)))
        else $error("left pin pair inconsistent with duty");

    a_right_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (rpins_reg != 2'b11) && ((rpins_reg != PINS_OFF) == (rduty_reg != 8'd0)))
        else $error("right pin pair inconsistent with duty");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (state_reg == ST_DIV))
        else $error("divider started without wait state");

endmodule

// ----- sv/differential_drive_mixer_failsafe_top.sv -----
// ----------------------------------------------------------------------------
// differential_drive_mixer_failsafe_top
// Arcade mixer for a two-wheel drive with command-timeout failsafe.
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall carry one word per drive command, stop
// command or 1 ms tick (operation, steer_value, throttle_value)
// output channel: out_valid/out_stall return one word per input word with
// both bridge pin pairs, both duties, led_on and failsafe_active
// config: cfg_we writes cfg_data into register cfg_index, one per cycle
// the back end takes one word at a time through queue pop, mix multiply,
// duty multiply and output load, and pops no new word before the last loads
// in failsafe a divider step between duty and output waits on a bit-serial
// divider for the blink phase
// a 2-entry queue takes words while the back end works or the output stalls;
// in_stall rises only when that queue is full
// out_stall holds the result word; the back end waits, the queue fills
// reset: motor regs off, not res, timers 0, cfg defaults, no word in flight
// ----------------------------------------------------------------------------
module differential_drive_mixer_failsafe_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic signed [15:0]              steer_value,
    input  logic signed [15:0]              throttle_value,
    input  logic                            cfg_we,
    input  logic [ddmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddmf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            left_in_a,
    output logic                            left_in_b,
    output logic [7:0]                      left_duty,
    output logic                            right_in_a,
    output logic                            right_in_b,
    output logic [7:0]                      right_duty,
    output logic                            led_on,
    output logic                            failsafe_active
);
    import ddmf_pkg::*;

    cfg_t cfg;
    cmd_t push_data, pop_data;
    res_t res;
    logic q_push, q_full, q_pop, q_empty;

    ddmf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .steer_value    (steer_value),
        .throttle_value (throttle_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (push_data),
        .cfg            (cfg)
    );

    ddmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    ddmf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign left_in_a       = res.left_pins[0];
    assign left_in_b       = res.left_pins[1];
    assign left_duty       = res.left_duty;
    assign right_in_a      = res.right_pins[0];
    assign right_in_b      = res.right_pins[1];
    assign right_duty      = res.right_duty;
    assign led_on          = res.led_on;
    assign failsafe_active = res.failsafe;

endmodule
